@@ design/lef_pkg.sv @@
package lef_pkg;

    // bank size and number format
    localparam int LANDMARKS     = 64;
    localparam int LM_AW         = $clog2(LANDMARKS);
    localparam int FRACTION_BITS = 16;
    localparam int ALPHA_BITS    = 30;
    localparam int CFG_W         = 26;

    // velocity dividend |diff| * 1e6 stays below 2^52
    localparam int VEL_DIV_STEPS = 52;
    localparam int QUOT_W        = VEL_DIV_STEPS;
    localparam int CNT_W         = $clog2(VEL_DIV_STEPS + 1);

    localparam logic [19:0] US_PER_S  = 20'd1000000;
    localparam logic [31:0] MIN_DT_US = 32'd10;

    // 2^F * 1e6 / (2*pi), the +1 term of w/(w+1) scaled to fc*dt units
    localparam logic [63:0] ALPHA_DEN =
        64'((64'd1000000 << FRACTION_BITS) * 64'd1000000 / 64'd6283185);
    localparam logic [30:0] ALPHA_ONE  = 31'(64'd1 << ALPHA_BITS);
    localparam logic [65:0] ALPHA_HALF = 66'(64'd1 << (ALPHA_BITS - 1));

    // register map, paddr[3:2]
    localparam logic [1:0] REG_MIN_CUTOFF   = 2'd0;
    localparam logic [1:0] REG_SPEED_COEF   = 2'd1;
    localparam logic [1:0] REG_RATE_CUTOFF  = 2'd2;

    localparam logic [CFG_W-1:0] MIN_CUTOFF_RST  = 26'd65536;
    localparam logic [CFG_W-1:0] SPEED_COEF_RST  = 26'd0;
    localparam logic [CFG_W-1:0] RATE_CUTOFF_RST = 26'd65536;

    // per-landmark state word: {last_time, y_speed, x_speed, y_est, x_est}
    localparam int STATE_W = 160;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAG,
        ST_VDIV,
        ST_DIV,
        ST_VEL,
        ST_ALOAD,
        ST_BL1,
        ST_BL2,
        ST_BL3,
        ST_SPD,
        ST_FC,
        ST_FCMUL,
        ST_WRITE
    } state_t;

endpackage

@@ design/landmark_one_euro_filter_bank.sv @@
// channel   | dir | signals                          | contents
// s_ stream | in  | s_tvalid s_tready s_tdata s_tuser | landmark sample or clear-all
// m_ stream | out | m_tvalid m_tready m_tdata        | filtered landmark
// apb cfg   | in  | psel penable pwrite paddr pwdata | cutoff and speed registers
//
// a sample runs per axis one 52-step velocity division and two 30-step alpha divisions
// on the shared restoring divider, plus the multiplies on the shared multiplier; a first
// sample after clear skips these and goes from load straight to write-back
// a clear transaction is taken in idle and gives no result
// aresetn is synchronous, active low; it re-arms every landmark and loads register defaults
// s_tready is high only in idle; the result waits in an output register, a stalled m_ side
// holds the next sample at its write-back
module landmark_one_euro_filter_bank (
    input  logic         aclk,
    input  logic         aresetn,
    // apb configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // landmark_index[5:0], x_coord[37:6], y_coord[69:38],
                                    // time_us[101:70], zero pad
    input  logic [0:0]   s_tuser,   // kind[0]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata    // out_index[5:0], x_filtered[37:6], y_filtered[69:38],
                                    // zero pad
);

    // configuration registers
    logic [lef_pkg::CFG_W-1:0] min_cutoff_reg;
    logic [lef_pkg::CFG_W-1:0] speed_coef_reg;
    logic [lef_pkg::CFG_W-1:0] rate_cutoff_reg;

    // sequencer
    lef_pkg::state_t state_reg, state_next;
    lef_pkg::state_t ret_reg, ret_next;
    logic            axis_reg, axis_next;
    logic            phase_reg, phase_next;   // 0 = speed blend, 1 = position blend

    // current item
    logic [5:0]           idx_reg;
    logic signed [31:0]   x_in_reg, y_in_reg;
    logic [31:0]          t_reg;
    logic                 first_reg;
    logic [lef_pkg::LANDMARKS-1:0] awaiting_reg;

    // per-axis filter state loaded from the bank
    logic signed [31:0] est_reg [2];
    logic signed [31:0] spd_reg [2];
    logic [31:0]        dt_reg;

    // datapath
    logic                  diff_neg_reg;
    logic signed [31:0]    vel_reg;
    logic signed [31:0]    vs_reg;
    logic [31:0]           fc_reg;
    logic [29:0]           alpha_reg;
    logic signed [65:0]    prod_reg;
    logic signed [65:0]    acc_reg;

    // shared restoring divider
    logic [63:0]                  rem_reg, num_reg, den_reg;
    logic [lef_pkg::QUOT_W-1:0]   q_reg;
    logic [lef_pkg::CNT_W-1:0]    cnt_reg;

    // output register
    logic        m_valid_reg;
    logic [71:0] m_data_reg;

    // bank memory
    logic                        ram_we, ram_re;
    logic [lef_pkg::STATE_W-1:0] ram_wdata, ram_rdata;

    // --------------------------------------------------------------------
    // handshakes
    logic in_fire, cfg_wr;
    logic in_kind;
    logic [5:0] in_idx;
    logic in_range;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign s_tready = (state_reg == lef_pkg::ST_IDLE);
    assign in_fire  = s_tvalid & s_tready;
    assign in_kind  = s_tuser[0];
    assign in_idx   = s_tdata[5:0];
    assign in_range = (int'(in_idx) < lef_pkg::LANDMARKS);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        unique case (paddr[3:2])
            lef_pkg::REG_MIN_CUTOFF:  prdata = 32'(min_cutoff_reg);
            lef_pkg::REG_SPEED_COEF:  prdata = 32'(speed_coef_reg);
            lef_pkg::REG_RATE_CUTOFF: prdata = 32'(rate_cutoff_reg);
            default:                  prdata = 32'd0;
        endcase
    end

    // --------------------------------------------------------------------
    // combinational helpers

    // position difference and its magnitude for the velocity estimate
    logic signed [31:0] v_sel, est_sel, spd_sel;
    logic signed [32:0] diff;
    logic [32:0]        abs_diff;

    assign v_sel   = axis_reg ? y_in_reg : x_in_reg;
    assign est_sel = est_reg[axis_reg];
    assign spd_sel = spd_reg[axis_reg];
    assign diff    = {v_sel[31], v_sel} - {est_sel[31], est_sel};
    assign abs_diff = diff[32] ? 33'(-diff) : 33'(diff);

    // dt from the stored timestamp, replaced by the floor when not positive
    logic signed [32:0] dt_raw;
    assign dt_raw = {1'b0, t_reg} - {1'b0, ram_rdata[159:128]};

    // saturated velocity from the quotient
    logic signed [31:0] vel_sat;
    always_comb begin
        if (!diff_neg_reg) begin
            vel_sat = (q_reg > lef_pkg::QUOT_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF
                                                               : 32'(q_reg);
        end else begin
            vel_sat = (q_reg > lef_pkg::QUOT_W'(32'h80000000)) ? 32'sh80000000
                                                               : 32'(-q_reg);
        end
    end

    // p = fc*dt scaled below 2^61, e scaled alike
    logic [63:0] p_full, p_scaled, e_scaled;
    assign p_full = prod_reg[63:0];
    always_comb begin
        priority if (p_full[63]) begin
            p_scaled = p_full >> 3;
            e_scaled = lef_pkg::ALPHA_DEN >> 3;
        end else if (p_full[62]) begin
            p_scaled = p_full >> 2;
            e_scaled = lef_pkg::ALPHA_DEN >> 2;
        end else if (p_full[61]) begin
            p_scaled = p_full >> 1;
            e_scaled = lef_pkg::ALPHA_DEN >> 1;
        end else begin
            p_scaled = p_full;
            e_scaled = lef_pkg::ALPHA_DEN;
        end
    end

    // divider step
    logic [63:0] rem_shift;
    logic        rem_ge;
    assign rem_shift = {rem_reg[62:0], num_reg[63]};
    assign rem_ge    = (rem_shift >= den_reg);

    // blend sum, shift by alpha bits rounded to nearest
    logic signed [65:0] blend_sum;
    assign blend_sum = acc_reg + prod_reg + lef_pkg::ALPHA_HALF;

    // cutoff from smoothed speed, saturated to 32 bits
    logic [31:0] abs_vs;
    logic [41:0] fc_sum;
    assign abs_vs = vs_reg[31] ? 32'(-vs_reg) : 32'(vs_reg);
    assign fc_sum = 42'(min_cutoff_reg)
                  + prod_reg[lef_pkg::FRACTION_BITS+41:lef_pkg::FRACTION_BITS];

    // shared multiplier
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic [30:0]        one_minus_alpha;

    assign one_minus_alpha = lef_pkg::ALPHA_ONE - {1'b0, alpha_reg};

    always_comb begin
        unique case (state_reg)
            lef_pkg::ST_MAG: begin
                mul_a = {1'b0, abs_diff};
                mul_b = 34'(lef_pkg::US_PER_S);
            end
            lef_pkg::ST_VEL: begin
                mul_a = 34'(rate_cutoff_reg);
                mul_b = 34'(dt_reg);
            end
            lef_pkg::ST_BL1: begin
                mul_a = 34'(q_reg[29:0]);
                mul_b = phase_reg ? 34'(v_sel) : 34'(vel_reg);
            end
            lef_pkg::ST_BL2: begin
                mul_a = 34'(one_minus_alpha);
                mul_b = phase_reg ? 34'(est_sel) : 34'(spd_sel);
            end
            lef_pkg::ST_SPD: begin
                mul_a = 34'(speed_coef_reg);
                mul_b = 34'(abs_vs);
            end
            lef_pkg::ST_FCMUL: begin
                mul_a = 34'(fc_reg);
                mul_b = 34'(dt_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // --------------------------------------------------------------------
    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lef_pkg::ST_IDLE: begin
                if (in_fire && !in_kind && in_range) begin
                    state_next = lef_pkg::ST_LOAD;
                end
            end
            lef_pkg::ST_LOAD:  state_next = first_reg ? lef_pkg::ST_WRITE : lef_pkg::ST_MAG;
            lef_pkg::ST_MAG:   state_next = lef_pkg::ST_VDIV;
            lef_pkg::ST_VDIV:  state_next = lef_pkg::ST_DIV;
            lef_pkg::ST_DIV: begin
                if (cnt_reg == lef_pkg::CNT_W'(1)) begin
                    state_next = ret_reg;
                end
            end
            lef_pkg::ST_VEL:   state_next = lef_pkg::ST_ALOAD;
            lef_pkg::ST_ALOAD: state_next = lef_pkg::ST_DIV;
            lef_pkg::ST_BL1:   state_next = lef_pkg::ST_BL2;
            lef_pkg::ST_BL2:   state_next = lef_pkg::ST_BL3;
            lef_pkg::ST_BL3: begin
                if (!phase_reg) begin
                    state_next = lef_pkg::ST_SPD;
                end else if (!axis_reg) begin
                    state_next = lef_pkg::ST_MAG;
                end else begin
                    state_next = lef_pkg::ST_WRITE;
                end
            end
            lef_pkg::ST_SPD:   state_next = lef_pkg::ST_FC;
            lef_pkg::ST_FC:    state_next = lef_pkg::ST_FCMUL;
            lef_pkg::ST_FCMUL: state_next = lef_pkg::ST_ALOAD;
            lef_pkg::ST_WRITE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = lef_pkg::ST_IDLE;
                end
            end
            default:           state_next = lef_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ret_next   = ret_reg;
        axis_next  = axis_reg;
        phase_next = phase_reg;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        unique case (state_reg)
            lef_pkg::ST_IDLE:  ram_re = in_fire;
            lef_pkg::ST_LOAD:  axis_next = 1'b0;
            lef_pkg::ST_MAG:   phase_next = 1'b0;
            lef_pkg::ST_VDIV:  ret_next = lef_pkg::ST_VEL;
            lef_pkg::ST_ALOAD: ret_next = lef_pkg::ST_BL1;
            lef_pkg::ST_BL3: begin
                if (phase_reg && !axis_reg) begin
                    axis_next = 1'b1;
                end
            end
            lef_pkg::ST_FCMUL: phase_next = 1'b1;
            lef_pkg::ST_WRITE: ram_we = !m_valid_reg || m_tready;
            default: begin
            end
        endcase
    end

    assign ram_wdata = {t_reg, spd_reg[1], spd_reg[0], est_reg[1], est_reg[0]};

    lef_ram #(
        .WIDTH (lef_pkg::STATE_W),
        .DEPTH (lef_pkg::LANDMARKS)
    ) u_bank (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg[lef_pkg::LM_AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (in_idx[lef_pkg::LM_AW-1:0]),
        .rdata (ram_rdata)
    );

    // --------------------------------------------------------------------
    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= lef_pkg::ST_IDLE;
            ret_reg         <= lef_pkg::ST_IDLE;
            axis_reg        <= 1'b0;
            phase_reg       <= 1'b0;
            awaiting_reg    <= '1;
            m_valid_reg     <= 1'b0;
            min_cutoff_reg  <= lef_pkg::MIN_CUTOFF_RST;
            speed_coef_reg  <= lef_pkg::SPEED_COEF_RST;
            rate_cutoff_reg <= lef_pkg::RATE_CUTOFF_RST;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            axis_reg  <= axis_next;
            phase_reg <= phase_next;

            if (cfg_wr) begin
                unique case (paddr[3:2])
                    lef_pkg::REG_MIN_CUTOFF:  min_cutoff_reg  <= pwdata[lef_pkg::CFG_W-1:0];
                    lef_pkg::REG_SPEED_COEF:  speed_coef_reg  <= pwdata[lef_pkg::CFG_W-1:0];
                    lef_pkg::REG_RATE_CUTOFF: rate_cutoff_reg <= pwdata[lef_pkg::CFG_W-1:0];
                    default: begin
                    end
                endcase
            end

            // clear transaction re-arms the whole bank
            if (in_fire && in_kind) begin
                awaiting_reg <= '1;
            end else if (ram_we) begin
                awaiting_reg[idx_reg[lef_pkg::LM_AW-1:0]] <= 1'b0;
            end

            if (ram_we) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // --------------------------------------------------------------------
    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            lef_pkg::ST_IDLE: begin
                if (in_fire) begin
                    idx_reg   <= in_idx;
                    x_in_reg  <= s_tdata[37:6];
                    y_in_reg  <= s_tdata[69:38];
                    t_reg     <= s_tdata[101:70];
                    first_reg <= awaiting_reg[in_idx[lef_pkg::LM_AW-1:0]];
                end
            end
            lef_pkg::ST_LOAD: begin
                if (first_reg) begin
                    est_reg[0] <= x_in_reg;
                    est_reg[1] <= y_in_reg;
                    spd_reg[0] <= '0;
                    spd_reg[1] <= '0;
                end else begin
                    est_reg[0] <= ram_rdata[31:0];
                    est_reg[1] <= ram_rdata[63:32];
                    spd_reg[0] <= ram_rdata[95:64];
                    spd_reg[1] <= ram_rdata[127:96];
                end
                dt_reg <= (dt_raw <= 0) ? lef_pkg::MIN_DT_US : dt_raw[31:0];
            end
            lef_pkg::ST_MAG: begin
                prod_reg     <= mul_p[65:0];
                diff_neg_reg <= diff[32];
            end
            lef_pkg::ST_VDIV: begin
                rem_reg <= '0;
                num_reg <= prod_reg[63:0] << (64 - lef_pkg::VEL_DIV_STEPS);
                den_reg <= 64'(dt_reg);
                q_reg   <= '0;
                cnt_reg <= lef_pkg::CNT_W'(lef_pkg::VEL_DIV_STEPS);
            end
            lef_pkg::ST_DIV: begin
                rem_reg <= rem_ge ? rem_shift - den_reg : rem_shift;
                num_reg <= num_reg << 1;
                q_reg   <= {q_reg[lef_pkg::QUOT_W-2:0], rem_ge};
                cnt_reg <= cnt_reg - lef_pkg::CNT_W'(1);
            end
            lef_pkg::ST_VEL: begin
                vel_reg  <= vel_sat;
                prod_reg <= mul_p[65:0];
            end
            lef_pkg::ST_ALOAD: begin
                rem_reg <= p_scaled;
                num_reg <= '0;
                den_reg <= p_scaled + e_scaled;
                q_reg   <= '0;
                cnt_reg <= lef_pkg::CNT_W'(lef_pkg::ALPHA_BITS);
            end
            lef_pkg::ST_BL1: begin
                alpha_reg <= q_reg[29:0];
                prod_reg  <= mul_p[65:0];
            end
            lef_pkg::ST_BL2: begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p[65:0];
            end
            lef_pkg::ST_BL3: begin
                if (!phase_reg) begin
                    vs_reg <= blend_sum[61:30];
                end else begin
                    est_reg[axis_reg] <= blend_sum[61:30];
                    spd_reg[axis_reg] <= vs_reg;
                end
            end
            lef_pkg::ST_SPD: begin
                prod_reg <= mul_p[65:0];
            end
            lef_pkg::ST_FC: begin
                fc_reg <= (fc_sum[41:32] != '0) ? 32'hFFFFFFFF : fc_sum[31:0];
            end
            lef_pkg::ST_FCMUL: begin
                prod_reg <= mul_p[65:0];
            end
            lef_pkg::ST_WRITE: begin
                if (ram_we) begin
                    m_data_reg <= {2'b00, est_reg[1], est_reg[0], idx_reg};
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ design/lef_ram.sv @@
module lef_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
